/* hw/rtl/tmce_pkg.sv */
// Shared types, codes and defaults for the text-mode console engine.
package tmce_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Character and attribute constants.
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    // Action codes carried in the command word.
    localparam logic [2:0] ACT_WRITE     = 3'd0;
    localparam logic [2:0] ACT_BACKSPACE = 3'd1;
    localparam logic [2:0] ACT_CLEAR     = 3'd2;
    localparam logic [2:0] ACT_SET_COLOR = 3'd3;
    localparam logic [2:0] ACT_READ      = 3'd4;

    // Command word.
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic [10:0] cursor_position;
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic        cursor_updated;
        logic        scrolled;
        logic [15:0] cell_data;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } state_t;

endpackage

/* hw/rtl/tmce_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module tmce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/text_mode_console_engine.sv */
// Top level of the text-mode console engine: cursor control and screen sequencer.
//
//  Channel   Ports               Handshake
//  --------  ------------------  ----------------------------------------------
//  command   start, busy, cmd    word taken at a clock edge with start=1, busy=0
//  result    done, result        word valid for the single cycle that done is 1
//
//  Write char and newline (unless they scroll), backspace, set color and an
//  out-of-range read show their result in the next cycle, and a new word can be
//  taken then. A cell read goes through ST_READ for its one memory read. A scroll
//  copies the screen up one row through the single memory port pair, then
//  blanks the bottom row. A clear sweeps every cell. After reset a clearing
//  pass writes every cell blank with busy high. The receiver cannot stall the
//  result channel.
module text_mode_console_engine #(
    parameter int COLUMNS = tmce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmce_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tmce_pkg::cmd_t    cmd,
    output logic              done,
    output tmce_pkg::result_t result
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    localparam logic [AW-1:0] LAST_CELL     = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] COL_STEP      = AW'(COLUMNS);
    localparam logic [RW-1:0] ROW_LAST      = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST      = CW'(COLUMNS - 1);

    tmce_pkg::state_t state_reg, state_next;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [AW-1:0] cpos_reg, cpos_next;
    logic [7:0]    color_reg, color_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic [AW-1:0] copy_wa_reg, copy_wa_next;
    logic          copy_vld_reg, copy_vld_next;
    logic          upd_reg, upd_next;
    logic          scr_reg, scr_next;
    logic          done_reg, done_next;
    tmce_pkg::result_t res_reg, res_next;

    logic          accept;
    logic          scroll_hit;
    logic          is_newline;
    logic          in_range;
    logic          sweep_end;
    logic          finish;
    logic [15:0]   data_w;
    logic [31:0]   idx_ext;
    logic [31:0]   pos_ext;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    // Screen memory: one cell word per entry.
    tmce_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Decode of the incoming word.
    assign accept     = start && (state_reg == tmce_pkg::ST_IDLE);
    assign is_newline = (cmd.char_code == tmce_pkg::NEWLINE_CHAR);
    assign scroll_hit = (cmd.action == tmce_pkg::ACT_WRITE) && (row_reg == ROW_LAST)
                        && (is_newline || (col_reg == COL_LAST));
    assign idx_ext    = 32'(cmd.cell_index);
    assign in_range   = (idx_ext < 32'(CELL_COUNT));
    assign sweep_end  = (sweep_reg == LAST_CELL);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmce_pkg::ST_INIT:
            begin
                if (sweep_end)
                begin
                    state_next = tmce_pkg::ST_IDLE;
                end
            end
            tmce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.action)
                        tmce_pkg::ACT_WRITE:
                        begin
                            if (scroll_hit)
                            begin
                                state_next = tmce_pkg::ST_SCROLL;
                            end
                        end
                        tmce_pkg::ACT_CLEAR:
                        begin
                            state_next = tmce_pkg::ST_FILL;
                        end
                        tmce_pkg::ACT_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = tmce_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = tmce_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tmce_pkg::ST_READ:
            begin
                state_next = tmce_pkg::ST_IDLE;
            end
            tmce_pkg::ST_SCROLL:
            begin
                if (sweep_end)
                begin
                    state_next = tmce_pkg::ST_FILL;
                end
            end
            tmce_pkg::ST_FILL:
            begin
                if (!copy_vld_reg && sweep_end)
                begin
                    state_next = tmce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmce_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath: cursor updates, memory accesses and result assembly.
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        cpos_next     = cpos_reg;
        color_next    = color_reg;
        sweep_next    = sweep_reg;
        copy_wa_next  = copy_wa_reg;
        copy_vld_next = 1'b0;
        upd_next      = upd_reg;
        scr_next      = scr_reg;
        finish        = 1'b0;
        data_w        = '0;
        ram_we        = 1'b0;
        ram_waddr     = copy_wa_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = sweep_reg;

        // A copied row word is written in the cycle after its read.
        if (copy_vld_reg)
        begin
            ram_we = 1'b1;
        end

        case (state_reg)
            tmce_pkg::ST_INIT, tmce_pkg::ST_FILL:
            begin
                // Blank fill; it waits while the last copy write drains.
                if (!copy_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sweep_reg;
                    ram_wdata = {color_reg, tmce_pkg::BLANK_CHAR};
                    if (!sweep_end)
                    begin
                        sweep_next = sweep_reg + AW'(1);
                    end
                    else if (state_reg == tmce_pkg::ST_FILL)
                    begin
                        finish = 1'b1;
                    end
                end
            end
            tmce_pkg::ST_SCROLL:
            begin
                // Read one row below, write it back one row up next cycle.
                copy_vld_next = 1'b1;
                copy_wa_next  = sweep_reg - COL_STEP;
                if (sweep_end)
                begin
                    sweep_next = LAST_ROW_BASE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            tmce_pkg::ST_READ:
            begin
                finish = 1'b1;
                data_w = ram_rdata;
            end
            tmce_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    upd_next = 1'b0;
                    scr_next = 1'b0;
                    case (cmd.action)
                        tmce_pkg::ACT_WRITE:
                        begin
                            upd_next = 1'b1;
                            scr_next = scroll_hit;
                            finish   = !scroll_hit;
                            if (!is_newline)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cpos_reg;
                                ram_wdata = {color_reg, cmd.char_code};
                            end
                            if (is_newline || (col_reg == COL_LAST))
                            begin
                                col_next = '0;
                                if (scroll_hit)
                                begin
                                    cpos_next  = LAST_ROW_BASE;
                                    sweep_next = COL_STEP;
                                end
                                else
                                begin
                                    row_next  = row_reg + RW'(1);
                                    cpos_next = cpos_reg - AW'(col_reg) + COL_STEP;
                                end
                            end
                            else
                            begin
                                col_next  = col_reg + CW'(1);
                                cpos_next = cpos_reg + AW'(1);
                            end
                        end
                        tmce_pkg::ACT_BACKSPACE:
                        begin
                            finish = 1'b1;
                            if ((row_reg != '0) || (col_reg != '0))
                            begin
                                upd_next  = 1'b1;
                                cpos_next = cpos_reg - AW'(1);
                                ram_we    = 1'b1;
                                ram_waddr = cpos_reg - AW'(1);
                                ram_wdata = {color_reg, tmce_pkg::BLANK_CHAR};
                                if (col_reg == '0)
                                begin
                                    col_next = COL_LAST;
                                    row_next = row_reg - RW'(1);
                                end
                                else
                                begin
                                    col_next = col_reg - CW'(1);
                                end
                            end
                        end
                        tmce_pkg::ACT_CLEAR:
                        begin
                            upd_next   = 1'b1;
                            color_next = cmd.color;
                            row_next   = '0;
                            col_next   = '0;
                            cpos_next  = '0;
                            sweep_next = '0;
                        end
                        tmce_pkg::ACT_SET_COLOR:
                        begin
                            color_next = cmd.color;
                            finish     = 1'b1;
                        end
                        tmce_pkg::ACT_READ:
                        begin
                            ram_raddr = idx_ext[AW-1:0];
                            finish    = !in_range;
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase

        // Result word, built from the cursor as it stands after the step.
        pos_ext   = 32'(cpos_next);
        row_ext   = 32'(row_next);
        col_ext   = 32'(col_next);
        done_next = finish;
        res_next  = res_reg;
        if (finish)
        begin
            res_next.cursor_position = pos_ext[10:0];
            res_next.cursor_row_out  = row_ext[4:0];
            res_next.cursor_col_out  = col_ext[6:0];
            res_next.cursor_updated  = upd_next;
            res_next.scrolled        = scr_next;
            res_next.cell_data       = data_w;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tmce_pkg::ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            cpos_reg     <= '0;
            color_reg    <= tmce_pkg::RESET_COLOR;
            sweep_reg    <= '0;
            copy_vld_reg <= 1'b0;
            upd_reg      <= 1'b0;
            scr_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            cpos_reg     <= cpos_next;
            color_reg    <= color_next;
            sweep_reg    <= sweep_next;
            copy_vld_reg <= copy_vld_next;
            upd_reg      <= upd_next;
            scr_reg      <= scr_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        copy_wa_reg <= copy_wa_next;
        res_reg     <= res_next;
    end

    assign busy   = (state_reg != tmce_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hw/rtl/tmce_checker.sv */
// Port-level checker for the text-mode console engine, bound to the top level.
module tmce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input tmce_pkg::cmd_t    cmd,
    input logic              done,
    input tmce_pkg::result_t result
);

    logic accept;

    assign accept = start && !busy;

    // A result word only follows an accepted word or a busy period.
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(accept) || $past(busy)))
        else $error("result word without a pending command");

    // Set color answers in the next cycle without a cursor update or cell data.
    a_set_color: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.action == tmce_pkg::ACT_SET_COLOR))
        |=> (done && !result.cursor_updated && (result.cell_data == 16'h0000)))
        else $error("set color result is wrong");

    // Backspace answers in the next cycle and leaves the block ready.
    a_backspace: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.action == tmce_pkg::ACT_BACKSPACE)) |=> (done && !busy))
        else $error("backspace did not complete in one cycle");

    // A scroll only comes from a character write, which updates the cursor.
    a_scroll_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_updated
            && (result.cell_data == 16'h0000)))
        else $error("scroll reported without a cursor update");

endmodule

bind text_mode_console_engine tmce_checker u_tmce_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
);
